// File: hw/rtl/assert_macros.svh
// assertion macros used by the checker file pctt_checker
// no dependencies; expects clock and reset in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked every clock edge outside reset
`define PCTT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// checked every clock edge, reset included
`define PCTT_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

// File: hw/rtl/pctt_pkg.sv
// types and codes of the periodic callback timer table
// no dependencies
package pctt_pkg;

   localparam int HANDLE_W = 16;
   localparam int PID_W    = 16;
   localparam int PERIOD_W = 32;

   typedef enum logic [1:0] {
      REQ_TICK   = 2'd0,
      REQ_APPEND = 2'd1,
      REQ_REMOVE = 2'd2,
      REQ_CLEAR  = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_NOT_FOUND = 2'd2
   } status_code_type;

   typedef enum logic {
      KIND_FIRE = 1'b0,
      KIND_DONE = 1'b1
   } kind_code_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRIME,
      ST_TICK,
      ST_SEARCH,
      ST_SHIFT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      logic [PID_W-1:0]    owner;
      logic [PERIOD_W-1:0] period;
      logic [PERIOD_W-1:0] countdown;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic owner_hit;
      logic fire;
      logic handle_hit;
   } unit_flags_type;

endpackage

// File: hw/rtl/pctt_if.sv
// request and response channel interfaces of the timer table
// depends on pctt_pkg for field widths
interface req_if import pctt_pkg::*;;
   logic                valid;
   logic                ready;
   logic [1:0]          req_type;
   logic [HANDLE_W-1:0] handle;
   logic [PERIOD_W-1:0] period;
   logic [PID_W-1:0]    owner_pid;

   modport source (output valid, req_type, handle, period, owner_pid, input ready);
   modport sink (input valid, req_type, handle, period, owner_pid, output ready);
   modport monitor (input valid, ready, req_type, handle, period, owner_pid);
endinterface

interface rsp_if import pctt_pkg::*;;
   logic                valid;
   logic                ready;
   logic                kind;
   logic [HANDLE_W-1:0] fired_handle;
   logic [1:0]          status;
   logic                last;

   modport source (output valid, kind, fired_handle, status, last, input ready);
   modport sink (input valid, kind, fired_handle, status, last, output ready);
   modport monitor (input valid, ready, kind, fired_handle, status, last);
endinterface

// File: hw/rtl/periodic_callback_timer_table.sv
// channel    dir  handshake    payload
// req_ch     in   valid/ready  req_type, handle, period, owner_pid
// rsp_ch     out  valid/ready  kind, fired_handle, status, last
// tick and remove walk the used entries one per cycle through one ram read port,
// except that a tick holds its walk while the response side stalls a fire item
// append and clear go from idle straight to the done state; ready is high only between requests
// reset is synchronous; the table needs no clearing pass, the fill count marks its end
// depends on pctt_pkg, pctt_if, pctt_ram and pctt_entry_unit
module periodic_callback_timer_table import pctt_pkg::*; #(
   parameter int TABLE_DEPTH = 32
) (
   input logic  clock,
   input logic  reset,
   req_if.sink   req_ch,
   rsp_if.source rsp_ch
);
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in, cnt_next;
   logic [CNT_W-1:0]    used_ff, used_in;
   req_code_type        req_type_ff, req_type_in;
   logic [HANDLE_W-1:0] handle_ff, handle_in;
   logic [PID_W-1:0]    pid_ff, pid_in;
   status_code_type     status_ff, status_in;

   logic                rsp_valid_ff, rsp_valid_in;
   kind_code_type       rsp_kind_ff, rsp_kind_in;
   logic [HANDLE_W-1:0] rsp_handle_ff, rsp_handle_in;
   status_code_type     rsp_status_ff, rsp_status_in;
   logic                rsp_last_ff, rsp_last_in;

   logic           wr_en, rd_en;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   entry_type      wr_data, rd_entry, upd_entry;
   logic [ENTRY_W-1:0] rd_data;
   unit_flags_type flags;

   logic accept, out_free, last_entry, go_tick, load_rsp;
   req_code_type req_code;

   assign accept     = req_ch.valid && req_ch.ready;
   assign req_code   = req_code_type'(req_ch.req_type);
   assign out_free   = !rsp_valid_ff || rsp_ch.ready;
   assign cnt_next   = cnt_ff + CNT_W'(1);
   assign last_entry = (cnt_next == used_ff);
   assign go_tick    = !flags.fire || out_free;
   assign rd_entry   = entry_type'(rd_data);

   pctt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pctt_entry_unit u_unit (
      .entry_in  (rd_entry),
      .pid       (pid_ff),
      .handle    (handle_ff),
      .flags     (flags),
      .entry_out (upd_entry)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_code)
                  REQ_TICK:   state_in = (used_ff == '0) ? ST_DONE : ST_PRIME;
                  REQ_REMOVE: state_in = (used_ff == '0 || req_ch.handle == '0) ?
                                         ST_DONE : ST_PRIME;
                  default:    state_in = ST_DONE;
               endcase
            end
         end
         ST_PRIME:  state_in = (req_type_ff == REQ_TICK) ? ST_TICK : ST_SEARCH;
         ST_TICK: begin
            if (go_tick && last_entry) state_in = ST_DONE;
         end
         ST_SEARCH: begin
            if (flags.handle_hit) begin
               state_in = last_entry ? ST_DONE : ST_SHIFT;
            end else if (last_entry) begin
               state_in = ST_DONE;
            end
         end
         ST_SHIFT: begin
            if (last_entry) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and ram control
   always_comb begin
      cnt_in        = cnt_ff;
      used_in       = used_ff;
      req_type_in   = req_type_ff;
      handle_in     = handle_ff;
      pid_in        = pid_ff;
      status_in     = status_ff;
      wr_en         = 1'b0;
      wr_addr       = cnt_ff[IDX_W-1:0];
      wr_data       = upd_entry;
      rd_en         = 1'b0;
      rd_addr       = cnt_next[IDX_W-1:0];
      load_rsp      = 1'b0;
      rsp_kind_in   = KIND_FIRE;
      rsp_handle_in = '0;
      rsp_status_in = STATUS_OK;
      rsp_last_in   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_type_in = req_code;
               handle_in   = req_ch.handle;
               pid_in      = req_ch.owner_pid;
               cnt_in      = '0;
               status_in   = STATUS_OK;
               case (req_code)
                  REQ_APPEND: begin
                     if (req_ch.handle != '0) begin
                        if (used_ff >= DEPTH_CNT) begin
                           status_in = STATUS_FULL;
                        end else begin
                           wr_en             = 1'b1;
                           wr_addr           = used_ff[IDX_W-1:0];
                           wr_data.handle    = req_ch.handle;
                           wr_data.owner     = req_ch.owner_pid;
                           wr_data.period    = req_ch.period;
                           wr_data.countdown = req_ch.period;
                           used_in           = used_ff + CNT_W'(1);
                        end
                     end
                  end
                  REQ_REMOVE: begin
                     if (used_ff == '0 || req_ch.handle == '0) begin
                        status_in = STATUS_NOT_FOUND;
                     end
                  end
                  REQ_CLEAR: used_in = '0;
                  default: ;
               endcase
            end
         end
         ST_PRIME: begin
            rd_en   = 1'b1;
            rd_addr = '0;
         end
         ST_TICK: begin
            if (go_tick) begin
               wr_en         = flags.owner_hit;
               load_rsp      = flags.fire;
               rsp_handle_in = rd_entry.handle;
               rd_en         = !last_entry;
               cnt_in        = cnt_next;
            end
         end
         ST_SEARCH: begin
            rd_en = !last_entry;
            if (flags.handle_hit && last_entry) begin
               used_in = used_ff - CNT_W'(1);
            end else if (last_entry) begin
               status_in = STATUS_NOT_FOUND;
            end else begin
               cnt_in = cnt_next;
            end
         end
         ST_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff[IDX_W-1:0] - IDX_W'(1);
            wr_data = rd_entry;
            rd_en   = !last_entry;
            if (last_entry) begin
               used_in = used_ff - CNT_W'(1);
            end else begin
               cnt_in = cnt_next;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               load_rsp      = 1'b1;
               rsp_kind_in   = KIND_DONE;
               rsp_status_in = status_ff;
               rsp_last_in   = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_type_ff <= req_type_in;
      handle_ff   <= handle_in;
      pid_ff      <= pid_in;
      status_ff   <= status_in;
      if (load_rsp) begin
         rsp_kind_ff   <= rsp_kind_in;
         rsp_handle_ff <= rsp_handle_in;
         rsp_status_ff <= rsp_status_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign req_ch.ready        = (state_ff == ST_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.kind         = rsp_kind_ff;
   assign rsp_ch.fired_handle = rsp_handle_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.last         = rsp_last_ff;
endmodule

// File: hw/rtl/pctt_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module pctt_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 32
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic                                 rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: hw/rtl/pctt_entry_unit.sv
// shared per-entry unit: owner and handle compare, countdown decrement and reload
// depends on pctt_pkg
module pctt_entry_unit import pctt_pkg::*; (
   input  entry_type           entry_in,
   input  logic [PID_W-1:0]    pid,
   input  logic [HANDLE_W-1:0] handle,
   output unit_flags_type      flags,
   output entry_type           entry_out
);
   logic [PERIOD_W-1:0] dec;

   always_comb begin
      dec             = entry_in.countdown - PERIOD_W'(1);
      flags.owner_hit = (entry_in.owner == pid);
      flags.fire      = flags.owner_hit && (dec == '0);
      flags.handle_hit = (entry_in.handle == handle);
      entry_out       = entry_in;
      if (flags.fire) begin
         entry_out.countdown = entry_in.period;
      end else if (flags.owner_hit) begin
         entry_out.countdown = dec;
      end
   end
endmodule

// File: hw/rtl/pctt_checker.sv
// port-level checks of the timer table, bound to the top level
// depends on pctt_pkg and assert_macros.svh
`include "assert_macros.svh"

module pctt_checker import pctt_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic                rsp_kind,
   input logic [HANDLE_W-1:0] rsp_fired_handle,
   input logic                rsp_last
);
   `PCTT_ASSERT_ALWAYS(a_rsp_idle_after_reset, $past(reset) |-> !rsp_valid,
                       "rsp valid after reset")
   `PCTT_ASSERT(a_busy_after_accept, (req_valid && req_ready) |=> !req_ready,
                "ready right after accept")
   `PCTT_ASSERT(a_fire_while_busy, (rsp_valid && rsp_kind == KIND_FIRE) |->
                (!req_ready && !rsp_last && rsp_fired_handle != '0), "fire item outside a tick")
   `PCTT_ASSERT(a_rsp_hold, (rsp_valid && !rsp_ready) |=>
                (rsp_valid && $stable(rsp_fired_handle) && $stable(rsp_last)),
                "stalled rsp item changed")
endmodule

bind periodic_callback_timer_table pctt_checker u_pctt_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_kind         (rsp_ch.kind),
   .rsp_fired_handle (rsp_ch.fired_handle),
   .rsp_last         (rsp_ch.last)
);

// File: tb/testbench.sv
// self-checking bench for the periodic callback timer table: random and directed requests,
// expected fire and done items kept by a cycle-free model of the table
// depends on pctt_pkg, pctt_if and periodic_callback_timer_table
`timescale 1ns / 100ps

module testbench;
   import pctt_pkg::*;

   localparam int TABLE_SLOTS  = 32;
   localparam int STALL_LIMIT  = 4000;
   localparam int RANDOM_ITEMS = 170;
   localparam int SETTLE_WAIT  = 40;

   typedef struct {
      req_code_type        op;
      logic [HANDLE_W-1:0] handle;
      logic [PERIOD_W-1:0] period;
      logic [PID_W-1:0]    owner_pid;
      int                  idle_before;
      bit                  drain_first;
   } timer_request_type;

   typedef struct {
      kind_code_type       kind;
      logic [HANDLE_W-1:0] fired_handle;
      status_code_type     status;
      logic                last;
   } timer_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   req_if req_ch ();
   rsp_if rsp_ch ();

   periodic_callback_timer_table #(.TABLE_DEPTH(TABLE_SLOTS)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #4 clock = ~clock;

   // table copy used for prediction
   logic [HANDLE_W-1:0] tbl_handle    [TABLE_SLOTS];
   logic [PID_W-1:0]    tbl_owner     [TABLE_SLOTS];
   logic [PERIOD_W-1:0] tbl_period    [TABLE_SLOTS];
   logic [PERIOD_W-1:0] tbl_countdown [TABLE_SLOTS];
   int                  tbl_used;

   timer_request_type request_backlog[$];
   timer_result_type  due_results[$];

   timer_request_type staged_req;
   timer_request_type seen_req;
   timer_result_type  want;
   bit             have_staged;
   int             gap_left;
   int             send_run_left;
   int             recv_run_left;
   int             stall_left;
   int             stall_draw;
   int             idle_cycles;
   int             mismatch_count;
   int             queued_total;
   logic           req_taken;
   logic           rsp_taken;

   function automatic int draw_idle(inout int run_left);
      if (run_left > 0) begin
         run_left--;
         return 0;
      end
      if ($urandom_range(0, 11) == 0) begin
         run_left = $urandom_range(5, 20);
         return 0;
      end
      return $urandom_range(0, 19);
   endfunction

   function automatic void clear_timer_table();
      for (int k = 0; k < TABLE_SLOTS; k++) begin
         tbl_handle[k]    = '0;
         tbl_owner[k]     = '0;
         tbl_period[k]    = '0;
         tbl_countdown[k] = '0;
      end
      tbl_used = 0;
   endfunction

   function automatic void apply_timer_request(timer_request_type r);
      timer_result_type done;
      int            pos;
      done = '{kind: KIND_DONE, fired_handle: '0, status: STATUS_OK, last: 1'b1};
      case (r.op)
         REQ_TICK: begin
            for (int k = 0; k < tbl_used; k++) begin
               if (tbl_owner[k] == r.owner_pid) begin
                  tbl_countdown[k] = tbl_countdown[k] - PERIOD_W'(1);
                  if (tbl_countdown[k] == '0) begin
                     tbl_countdown[k] = tbl_period[k];
                     due_results.push_back('{kind: KIND_FIRE, fired_handle: tbl_handle[k],
                                             status: STATUS_OK, last: 1'b0});
                  end
               end
            end
         end
         REQ_APPEND: begin
            if (r.handle != '0) begin
               if (tbl_used >= TABLE_SLOTS) begin
                  done.status = STATUS_FULL;
               end else begin
                  tbl_handle[tbl_used]    = r.handle;
                  tbl_owner[tbl_used]     = r.owner_pid;
                  tbl_period[tbl_used]    = r.period;
                  tbl_countdown[tbl_used] = r.period;
                  tbl_used++;
               end
            end
         end
         REQ_REMOVE: begin
            pos = -1;
            if (r.handle != '0) begin
               for (int k = 0; k < tbl_used; k++) begin
                  if (pos < 0 && tbl_handle[k] == r.handle) pos = k;
               end
            end
            if (pos < 0) begin
               done.status = STATUS_NOT_FOUND;
            end else begin
               for (int k = pos + 1; k < tbl_used; k++) begin
                  tbl_handle[k-1]    = tbl_handle[k];
                  tbl_owner[k-1]     = tbl_owner[k];
                  tbl_period[k-1]    = tbl_period[k];
                  tbl_countdown[k-1] = tbl_countdown[k];
               end
               tbl_used--;
               tbl_handle[tbl_used]    = '0;
               tbl_owner[tbl_used]     = '0;
               tbl_period[tbl_used]    = '0;
               tbl_countdown[tbl_used] = '0;
            end
         end
         default: clear_timer_table();
      endcase
      due_results.push_back(done);
   endfunction

   function automatic void add_request(req_code_type op, logic [HANDLE_W-1:0] hnd,
                                       logic [PERIOD_W-1:0] per, logic [PID_W-1:0] pid,
                                       bit drain);
      timer_request_type item;
      item.op          = op;
      item.handle      = hnd;
      item.period      = per;
      item.owner_pid   = pid;
      item.idle_before = draw_idle(send_run_left);
      item.drain_first = drain;
      request_backlog.push_back(item);
      queued_total++;
   endfunction

   function automatic logic [HANDLE_W-1:0] pick_handle();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return HANDLE_W'($urandom_range(1, 8));
      if (r < 65) return '0;
      return HANDLE_W'($urandom_range(1, 65535));
   endfunction

   function automatic logic [PERIOD_W-1:0] pick_period();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return PERIOD_W'($urandom_range(1, 4));
      if (r < 80) return '0;
      return PERIOD_W'($urandom);
   endfunction

   function automatic logic [PID_W-1:0] pick_pid();
      if ($urandom_range(0, 99) < 80) return PID_W'($urandom_range(0, 3));
      return PID_W'($urandom_range(0, 65535));
   endfunction

   // clear, then fill past capacity with one owner, ticks of that owner mixed in, then tick that owner
   function automatic void fill_round();
      logic [PID_W-1:0] shared_pid;
      int               appended;
      shared_pid = PID_W'($urandom_range(0, 3));
      appended   = 0;
      add_request(REQ_CLEAR, HANDLE_W'($urandom), PERIOD_W'($urandom), PID_W'($urandom), 1'b0);
      while (appended < TABLE_SLOTS + 3) begin
         if ($urandom_range(0, 5) == 0) begin
            add_request(REQ_TICK, HANDLE_W'($urandom), PERIOD_W'($urandom), shared_pid, 1'b0);
         end else begin
            add_request(REQ_APPEND, HANDLE_W'($urandom_range(1, 65535)),
                        PERIOD_W'($urandom_range(1, 3)), shared_pid, 1'b0);
            appended++;
         end
      end
      repeat (4) add_request(REQ_TICK, HANDLE_W'($urandom), PERIOD_W'($urandom),
                             shared_pid, 1'b0);
   endfunction

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         have_staged = 1'b0;
         gap_left = 0;
      end else if (req_ch.valid && !req_taken) begin
      end else begin
         if (!have_staged && request_backlog.size() != 0) begin
            staged_req  = request_backlog.pop_front();
            have_staged = 1'b1;
            gap_left    = staged_req.idle_before;
         end
         if (have_staged && gap_left == 0 &&
             !(staged_req.drain_first && due_results.size() != 0)) begin
            req_ch.valid     <= 1'b1;
            req_ch.req_type  <= staged_req.op;
            req_ch.handle    <= staged_req.handle;
            req_ch.period    <= staged_req.period;
            req_ch.owner_pid <= staged_req.owner_pid;
            have_staged = 1'b0;
         end else begin
            req_ch.valid <= 1'b0;
            if (have_staged && gap_left > 0) gap_left--;
         end
      end
   end

   // response ready with random stalls
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left = 0;
      end else if (rsp_taken) begin
         stall_draw = draw_idle(recv_run_left);
         stall_left = stall_draw;
         rsp_ch.ready <= (stall_draw == 0);
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready <= (stall_left == 0);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // monitor, checker and watchdog
   always @(posedge clock) begin
      if (reset) begin
         req_taken   <= 1'b0;
         rsp_taken   <= 1'b0;
         idle_cycles <= 0;
      end else begin
         req_taken <= req_ch.valid && req_ch.ready;
         rsp_taken <= rsp_ch.valid && rsp_ch.ready;
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (due_results.size() == 0) begin
               $error("unexpected result item: kind %0d handle %0h status %0d last %0d",
                      rsp_ch.kind, rsp_ch.fired_handle, rsp_ch.status, rsp_ch.last);
               mismatch_count++;
            end else begin
               want = due_results.pop_front();
               if (rsp_ch.kind !== want.kind) begin
                  $error("kind expected %0d got %0d", want.kind, rsp_ch.kind);
                  mismatch_count++;
               end
               if (rsp_ch.fired_handle !== want.fired_handle) begin
                  $error("fired_handle expected %0h got %0h", want.fired_handle,
                         rsp_ch.fired_handle);
                  mismatch_count++;
               end
               if (rsp_ch.status !== want.status) begin
                  $error("status expected %0d got %0d", want.status, rsp_ch.status);
                  mismatch_count++;
               end
               if (rsp_ch.last !== want.last) begin
                  $error("last expected %0d got %0d", want.last, rsp_ch.last);
                  mismatch_count++;
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            seen_req.op        = req_code_type'(req_ch.req_type);
            seen_req.handle    = req_ch.handle;
            seen_req.period    = req_ch.period;
            seen_req.owner_pid = req_ch.owner_pid;
            apply_timer_request(seen_req);
         end
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= STALL_LIMIT) begin
            $error("no handshake for %0d cycles", idle_cycles);
            $display("[FAIL] regression broken");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      int r;
      req_ch.valid     = 1'b0;
      req_ch.req_type  = REQ_TICK;
      req_ch.handle    = '0;
      req_ch.period    = '0;
      req_ch.owner_pid = '0;
      rsp_ch.ready     = 1'b0;
      send_run_left    = 0;
      recv_run_left    = 0;
      mismatch_count   = 0;
      queued_total     = 0;
      clear_timer_table();

      // directed items
      add_request(REQ_TICK,   16'h0000, 32'h0000_0000, 16'h0000, 1'b0);
      add_request(REQ_REMOVE, 16'h0000, 32'h0000_0000, 16'h0000, 1'b0);
      add_request(REQ_APPEND, 16'h0000, 32'h0000_0005, 16'h0000, 1'b0);
      add_request(REQ_APPEND, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
      add_request(REQ_APPEND, 16'h0001, 32'h0000_0000, 16'h0000, 1'b0);
      add_request(REQ_APPEND, 16'h0002, 32'h0000_0001, 16'h0000, 1'b0);
      add_request(REQ_APPEND, 16'h0002, 32'h0000_0002, 16'h0000, 1'b0);
      add_request(REQ_APPEND, 16'h0003, 32'h0000_0003, 16'h0001, 1'b0);
      add_request(REQ_TICK,   16'hFFFF, 32'hFFFF_FFFF, 16'h0000, 1'b0);
      add_request(REQ_TICK,   16'h0000, 32'h0000_0000, 16'h0000, 1'b0);
      add_request(REQ_TICK,   16'h0000, 32'h0000_0000, 16'h0001, 1'b0);
      add_request(REQ_TICK,   16'h0000, 32'h0000_0000, 16'hFFFF, 1'b0);
      add_request(REQ_REMOVE, 16'h0002, 32'h0000_0000, 16'h0000, 1'b1);
      add_request(REQ_REMOVE, 16'h1234, 32'h0000_0000, 16'h0000, 1'b0);
      add_request(REQ_TICK,   16'h0000, 32'h0000_0000, 16'h0000, 1'b0);
      add_request(REQ_REMOVE, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
      add_request(REQ_CLEAR,  16'hA5A5, 32'h5A5A_5A5A, 16'h5A5A, 1'b0);
      add_request(REQ_TICK,   16'h0000, 32'h0000_0000, 16'h0000, 1'b0);
      add_request(REQ_REMOVE, 16'h0001, 32'h0000_0000, 16'h0000, 1'b0);
      add_request(REQ_APPEND, 16'h8000, 32'h8000_0000, 16'h8000, 1'b0);
      add_request(REQ_TICK,   16'h7FFF, 32'h7FFF_FFFF, 16'h8000, 1'b0);
      add_request(REQ_CLEAR,  16'h0000, 32'h0000_0000, 16'h0000, 1'b1);

      // random part
      fill_round();
      while (queued_total < RANDOM_ITEMS) begin
         if (queued_total > 110 && queued_total < 112) fill_round();
         r = $urandom_range(0, 99);
         if (r < 45) begin
            add_request(REQ_TICK, HANDLE_W'($urandom), PERIOD_W'($urandom), pick_pid(),
                        $urandom_range(0, 29) == 0);
         end else if (r < 72) begin
            add_request(REQ_APPEND, pick_handle(), pick_period(), pick_pid(),
                        $urandom_range(0, 29) == 0);
         end else if (r < 93) begin
            add_request(REQ_REMOVE, pick_handle(), PERIOD_W'($urandom), PID_W'($urandom),
                        $urandom_range(0, 29) == 0);
         end else if (r < 96) begin
            add_request(REQ_CLEAR, HANDLE_W'($urandom), PERIOD_W'($urandom),
                        PID_W'($urandom), 1'b0);
         end else begin
            add_request(req_code_type'($urandom_range(0, 3)), HANDLE_W'($urandom),
                        PERIOD_W'($urandom), PID_W'($urandom), 1'b0);
         end
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (request_backlog.size() != 0 || have_staged || req_ch.valid) @(posedge clock);
      while (due_results.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);

      if (due_results.size() != 0) begin
         $error("%0d expected result items never arrived", due_results.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
